// ----- rtl/per_process_deadline_watchdog_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-process deadline watchdog
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_PROCESS_DEADLINE_WATCHDOG_MACROS_SVH
`define PER_PROCESS_DEADLINE_WATCHDOG_MACROS_SVH

// Same-cycle implication.
`define PDW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pdw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_pkg
// Types and constants shared by the deadline watchdog modules.
// ----------------------------------------------------------------------------
package pdw_pkg;

    localparam int SLOTS        = 4096;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int SLOT_FIELD_W = 12;
    localparam int TIME_W       = 64;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic KIND_SWITCH  = 1'b0;
    localparam logic KIND_INSTALL = 1'b1;

    typedef enum logic
    {
        OP_SWITCH,
        OP_INSTALL
    } pdw_op_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE
    } pdw_state_t;

    typedef struct packed
    {
        pdw_op_t                  op;
        logic [SLOT_W-1:0]        slot;
        logic [TIME_W-1:0]        now_time;
        logic [TIME_W-1:0]        signature;
        logic [TIME_W-1:0]        limit;
        logic                     enforce;
    } pdw_item_t;

    typedef struct packed
    {
        logic present;
        logic running;
        logic flagged;
        logic enforce;
    } pdw_ctl_t;

    typedef struct packed
    {
        logic [TIME_W-1:0] signature;
        logic [TIME_W-1:0] limit;
    } pdw_contract_t;

    typedef struct packed
    {
        logic [SLOT_FIELD_W-1:0] event_slot;
        logic [TIME_W-1:0]       event_signature;
        logic [TIME_W-1:0]       elapsed_time;
        logic [TIME_W-1:0]       limit_time;
        logic [TIME_W-1:0]       event_time;
        logic                    raise_signal;
        logic [TIME_W-1:0]       violation_total;
    } pdw_result_t;

    typedef struct packed
    {
        logic clearing;
    } pdw_back_stat_t;

endpackage

// ----- rtl/pdw_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_req_if / pdw_vio_if
// Valid/ready channels for scheduler requests and violation events.
// ----------------------------------------------------------------------------
interface pdw_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [pdw_pkg::SLOT_FIELD_W-1:0]    slot;
    logic [pdw_pkg::TIME_W-1:0]          now_time;
    logic [pdw_pkg::TIME_W-1:0]          new_signature;
    logic [pdw_pkg::TIME_W-1:0]          new_limit;
    logic                                new_enforce;

    modport source
    (
        output valid, kind, slot, now_time, new_signature, new_limit, new_enforce,
        input  ready
    );

    modport sink
    (
        input  valid, kind, slot, now_time, new_signature, new_limit, new_enforce,
        output ready
    );
endinterface

interface pdw_vio_if;
    logic                                valid;
    logic                                ready;
    logic [pdw_pkg::SLOT_FIELD_W-1:0]    event_slot;
    logic [pdw_pkg::TIME_W-1:0]          event_signature;
    logic [pdw_pkg::TIME_W-1:0]          elapsed_time;
    logic [pdw_pkg::TIME_W-1:0]          limit_time;
    logic [pdw_pkg::TIME_W-1:0]          event_time;
    logic                                raise_signal;
    logic [pdw_pkg::TIME_W-1:0]          violation_total;

    modport source
    (
        output valid, event_slot, event_signature, elapsed_time, limit_time,
               event_time, raise_signal, violation_total,
        input  ready
    );

    modport sink
    (
        input  valid, event_slot, event_signature, elapsed_time, limit_time,
               event_time, raise_signal, violation_total,
        output ready
    );
endinterface

// ----- rtl/per_process_deadline_watchdog.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_process_deadline_watchdog
// Per-slot deadline contracts checked against scheduler switch timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   req  (valid/ready) carries install requests (kind 1: signature, limit,
//        enforce for a slot, clears its run state) and switch requests
//        (kind 0: slot and timestamp).
//   vio  (valid/ready) carries one event per first overrun of a nonzero
//        limit: slot, signature, elapsed, limit, timestamp, raise_signal
//        (CPU-limit signal wanted) and the running total.
//   Requests land in a four-entry queue; the table engine then takes each
//   request through pop and memory read, elapsed subtract, and compare and
//   write back, and pops the next only after the write-back, since the slot
//   tables are read-modify-write. A violation event is registered at the
//   end of the compare step.
//   After reset the engine clears all 4096 slots of the slot control table,
//   one slot a cycle, with req.ready held low; the violation count restarts at 0.
//   A stalled vio holds its event; the engine waits in its write-back step
//   and the queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module per_process_deadline_watchdog
(
    input  logic      clk,
    input  logic      rst_n,
    pdw_req_if.sink   req,
    pdw_vio_if.source vio
);

    pdw_pkg::pdw_back_stat_t stat;
    pdw_pkg::pdw_item_t      q_item;
    logic                    q_valid;
    logic                    q_pop;

    pdw_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .stat    (stat),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    pdw_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .stat    (stat),
        .vio     (vio)
    );

endmodule

// ----- rtl/pdw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_front
// Accepts requests, classifies them and queues them for the table engine.
// ----------------------------------------------------------------------------
module pdw_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    pdw_req_if.sink                req,
    input  pdw_pkg::pdw_back_stat_t stat,
    input  logic                   q_pop,
    output logic                   q_valid,
    output pdw_pkg::pdw_item_t     q_item
);

    pdw_pkg::pdw_item_t            q_mem_reg [pdw_pkg::Q_DEPTH];
    logic [pdw_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [pdw_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [pdw_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [pdw_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [pdw_pkg::Q_CNT_W-1:0]   cnt_reg;
    logic [pdw_pkg::Q_CNT_W-1:0]   cnt_next;
    logic                          accept;
    logic                          in_range;
    logic                          push;
    logic                          pop;
    pdw_pkg::pdw_item_t            item_in;

    // Hold off requests while the table is being cleared or the queue is full.
    assign req.ready = !stat.clearing && (cnt_reg != pdw_pkg::Q_CNT_W'(pdw_pkg::Q_DEPTH));
    assign accept    = req.valid && req.ready;

    // Drop requests for slots beyond the table.
    assign in_range  = int'(req.slot) < pdw_pkg::SLOTS;
    assign push      = accept && in_range;
    assign pop       = q_pop && q_valid;

    always_comb
    begin
        item_in.op        = (req.kind == pdw_pkg::KIND_INSTALL) ? pdw_pkg::OP_INSTALL
                                                                 : pdw_pkg::OP_SWITCH;
        item_in.slot      = pdw_pkg::SLOT_W'(req.slot);
        item_in.now_time  = req.now_time;
        item_in.signature = req.new_signature;
        item_in.limit     = req.new_limit;
        item_in.enforce   = req.new_enforce;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pdw_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + pdw_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + pdw_pkg::Q_CNT_W'(push) - pdw_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign q_valid = (cnt_reg != '0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

endmodule

// ----- rtl/pdw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_back
// Table engine: per-slot read-modify-write of contract and run state,
// violation detection, global counter and the event output register.
// ----------------------------------------------------------------------------
module pdw_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  pdw_pkg::pdw_item_t      q_item,
    output logic                    q_pop,
    output pdw_pkg::pdw_back_stat_t stat,
    pdw_vio_if.source               vio
);

    // Slot tables
    pdw_pkg::pdw_ctl_t             ctl_mem      [pdw_pkg::SLOTS];
    pdw_pkg::pdw_contract_t        contract_mem [pdw_pkg::SLOTS];
    logic [pdw_pkg::TIME_W-1:0]    start_mem    [pdw_pkg::SLOTS];
    pdw_pkg::pdw_ctl_t             ctl_rd_reg;
    pdw_pkg::pdw_contract_t        contract_rd_reg;
    logic [pdw_pkg::TIME_W-1:0]    start_rd_reg;

    pdw_pkg::pdw_state_t           state_reg;
    pdw_pkg::pdw_state_t           state_next;
    logic [pdw_pkg::SLOT_W-1:0]    clr_addr_reg;
    logic [pdw_pkg::SLOT_W-1:0]    clr_addr_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [pdw_pkg::TIME_W-1:0]    count_reg;
    logic [pdw_pkg::TIME_W-1:0]    count_next;
    pdw_pkg::pdw_item_t            item_reg;
    logic [pdw_pkg::TIME_W-1:0]    elapsed_reg;
    pdw_pkg::pdw_result_t          out_reg;
    pdw_pkg::pdw_result_t          out_next;

    logic                          clr_done;
    logic                          go;
    logic                          violate;
    logic                          emit;
    logic                          rd_en;
    logic [pdw_pkg::SLOT_W-1:0]    rd_addr;
    logic                          ctl_we;
    logic [pdw_pkg::SLOT_W-1:0]    ctl_waddr;
    pdw_pkg::pdw_ctl_t             ctl_wdata;
    logic                          contract_we;
    logic                          start_we;

    assign clr_done = (clr_addr_reg == pdw_pkg::SLOT_W'(pdw_pkg::SLOTS - 1));
    // The decide step retires only when the event register can take a result.
    assign go       = !out_valid_reg || vio.ready;
    assign violate  = (item_reg.op == pdw_pkg::OP_SWITCH) && ctl_rd_reg.present
                      && ctl_rd_reg.running && !ctl_rd_reg.flagged
                      && (contract_rd_reg.limit != '0)
                      && (elapsed_reg > contract_rd_reg.limit);
    assign emit     = (state_reg == pdw_pkg::ST_DECIDE) && go && violate;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pdw_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = pdw_pkg::ST_IDLE;
                end
            end
            pdw_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = pdw_pkg::ST_READ;
                end
            end
            pdw_pkg::ST_READ:
            begin
                state_next = pdw_pkg::ST_DECIDE;
            end
            pdw_pkg::ST_DECIDE:
            begin
                if (go)
                begin
                    state_next = pdw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdw_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = q_item.slot;
        ctl_we       = 1'b0;
        ctl_waddr    = item_reg.slot;
        ctl_wdata    = ctl_rd_reg;
        contract_we  = 1'b0;
        start_we     = 1'b0;
        stat.clearing = 1'b0;
        unique case (state_reg)
            pdw_pkg::ST_CLEAR:
            begin
                stat.clearing = 1'b1;
                ctl_we        = 1'b1;
                ctl_waddr     = clr_addr_reg;
                ctl_wdata     = '0;
            end
            pdw_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
                rd_en = q_valid;
            end
            pdw_pkg::ST_READ:
            begin
                ctl_we = 1'b0;
            end
            pdw_pkg::ST_DECIDE:
            begin
                if (go)
                begin
                    if (item_reg.op == pdw_pkg::OP_INSTALL)
                    begin
                        ctl_we            = 1'b1;
                        ctl_wdata.present = 1'b1;
                        ctl_wdata.running = 1'b0;
                        ctl_wdata.flagged = 1'b0;
                        ctl_wdata.enforce = item_reg.enforce;
                        contract_we       = 1'b1;
                    end
                    else if (ctl_rd_reg.present && !ctl_rd_reg.running)
                    begin
                        // First switch after install: record the start time.
                        ctl_we            = 1'b1;
                        ctl_wdata.running = 1'b1;
                        ctl_wdata.flagged = 1'b0;
                        start_we          = 1'b1;
                    end
                    else if (violate)
                    begin
                        ctl_we            = 1'b1;
                        ctl_wdata.flagged = 1'b1;
                    end
                end
            end
            default:
            begin
                stat.clearing = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next  = (state_reg == pdw_pkg::ST_CLEAR) ? clr_addr_reg + pdw_pkg::SLOT_W'(1)
                                                          : clr_addr_reg;
        count_next     = emit ? count_reg + pdw_pkg::TIME_W'(1) : count_reg;
        out_valid_next = emit || (out_valid_reg && !vio.ready);

        out_next.event_slot      = pdw_pkg::SLOT_FIELD_W'(item_reg.slot);
        out_next.event_signature = contract_rd_reg.signature;
        out_next.elapsed_time    = elapsed_reg;
        out_next.limit_time      = contract_rd_reg.limit;
        out_next.event_time      = item_reg.now_time;
        out_next.raise_signal    = ctl_rd_reg.enforce;
        out_next.violation_total = count_reg + pdw_pkg::TIME_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdw_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == pdw_pkg::ST_READ)
        begin
            elapsed_reg <= item_reg.now_time - start_rd_reg;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    // Table memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (ctl_we)
        begin
            ctl_mem[ctl_waddr] <= ctl_wdata;
        end
        if (rd_en)
        begin
            ctl_rd_reg <= ctl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (contract_we)
        begin
            contract_mem[item_reg.slot] <= '{signature: item_reg.signature,
                                             limit:     item_reg.limit};
        end
        if (rd_en)
        begin
            contract_rd_reg <= contract_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[item_reg.slot] <= item_reg.now_time;
        end
        if (rd_en)
        begin
            start_rd_reg <= start_mem[rd_addr];
        end
    end

    assign vio.valid           = out_valid_reg;
    assign vio.event_slot      = out_reg.event_slot;
    assign vio.event_signature = out_reg.event_signature;
    assign vio.elapsed_time    = out_reg.elapsed_time;
    assign vio.limit_time      = out_reg.limit_time;
    assign vio.event_time      = out_reg.event_time;
    assign vio.raise_signal    = out_reg.raise_signal;
    assign vio.violation_total = out_reg.violation_total;

endmodule

// ----- rtl/pdw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_checker
// Port-level checks on the deadline watchdog, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_process_deadline_watchdog_macros.svh"

module pdw_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_ready,
    input logic                              vio_valid,
    input logic                              vio_ready,
    input logic [pdw_pkg::SLOT_FIELD_W-1:0]  vio_slot,
    input logic [pdw_pkg::TIME_W-1:0]        vio_elapsed,
    input logic [pdw_pkg::TIME_W-1:0]        vio_limit,
    input logic [pdw_pkg::TIME_W-1:0]        vio_total
);

    logic                       started_reg;
    logic [pdw_pkg::TIME_W-1:0] last_total_reg;
    logic [pdw_pkg::TIME_W-1:0] last_total_next;

    assign last_total_next = (vio_valid && vio_ready) ? vio_total : last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            last_total_reg <= '0;
        end
        else
        begin
            started_reg    <= 1'b1;
            last_total_reg <= last_total_next;
        end
    end

    `PDW_ASSERT_NEXT(a_vio_hold, vio_valid && !vio_ready,
        vio_valid && $stable(vio_total) && $stable(vio_slot), "stalled event changed")

    `PDW_ASSERT_IMPL(a_vio_overrun, vio_valid,
        (vio_limit != '0) && (vio_elapsed > vio_limit), "event without an overrun")

    `PDW_ASSERT_IMPL(a_vio_count, vio_valid && vio_ready,
        vio_total == last_total_reg + pdw_pkg::TIME_W'(1), "violation total skipped")

    `PDW_ASSERT_IMPL(a_clear_hold, !started_reg,
        !req_ready, "request taken before the table was cleared")

endmodule

bind per_process_deadline_watchdog pdw_checker u_pdw_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ready   (req.ready),
    .vio_valid   (vio.valid),
    .vio_ready   (vio.ready),
    .vio_slot    (vio.event_slot),
    .vio_elapsed (vio.elapsed_time),
    .vio_limit   (vio.limit_time),
    .vio_total   (vio.violation_total)
);
